>>> rtl/core/bsc_pkg.sv
// Shared types, constants and helpers for the barometric compensation block.
`timescale 1ns / 1ps
package bsc_pkg;

  localparam int unsigned RegIdxW = 3;

  typedef enum logic [RegIdxW-1:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  localparam logic [1:0]  OssReset  = 2'd2;
  localparam logic [31:0] C4000     = 32'd4000;
  localparam logic [31:0] C32768    = 32'd32768;
  localparam logic [31:0] C50000    = 32'd50000;
  localparam logic [31:0] C3038     = 32'd3038;
  localparam logic [31:0] CNeg7357  = 32'hFFFF_E343;
  localparam logic [31:0] C3791     = 32'd3791;

  typedef struct packed {
    logic [31:0] ac1_ac2;
    logic [31:0] ac3_ac4;
    logic [31:0] ac5_ac6;
    logic [31:0] b1_b2;
    logic [31:0] mc_md;
    logic [1:0]  oss;
  } cal_t;

  function automatic logic [31:0] sx16(input logic [15:0] h);
    sx16 = {{16{h[15]}}, h};
  endfunction

  function automatic logic [31:0] asr(input logic [31:0] v, input logic [4:0] n);
    asr = 32'($signed(v) >>> n);
  endfunction

endpackage

>>> rtl/core/bsc_div.sv
// Pipelined unsigned 32-bit divider, one quotient bit per stage.
`timescale 1ns / 1ps
module bsc_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  logic [63:0] side_in,
  output logic        out_valid,
  output logic [31:0] quo,
  output logic [63:0] side_out
);
  import bsc_pkg::*;

  logic        v   [1:32];
  logic [31:0] rem [1:32];
  logic [31:0] q   [1:32];
  logic [31:0] d   [1:32];
  logic [63:0] sd  [1:32];

  for (genvar i = 0; i < 32; i++) begin : g_stage
    logic        v_in;
    logic [31:0] rem_in, q_in, d_in;
    logic [63:0] sd_in;
    logic [32:0] trial;
    logic [32:0] shifted;
    if (i == 0) begin : g_head
      assign v_in   = in_valid;
      assign rem_in = '0;
      assign q_in   = num;
      assign d_in   = den;
      assign sd_in  = side_in;
    end else begin : g_link
      assign v_in   = v[i];
      assign rem_in = rem[i];
      assign q_in   = q[i];
      assign d_in   = d[i];
      assign sd_in  = sd[i];
    end
    assign shifted = {rem_in, q_in[31]};
    assign trial   = shifted - {1'b0, d_in};
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else begin
        v[i+1] <= v_in;
      end
      d[i+1]  <= d_in;
      sd[i+1] <= sd_in;
      if (!trial[32]) begin
        rem[i+1] <= trial[31:0];
        q[i+1]   <= {q_in[30:0], 1'b1};
      end else begin
        rem[i+1] <= shifted[31:0];
        q[i+1]   <= {q_in[30:0], 1'b0};
      end
    end
  end

  assign out_valid = v[32];
  assign quo       = q[32];
  assign side_out  = sd[32];
endmodule

>>> rtl/core/bsc_sdiv.sv
// Signed 32-bit divider truncating toward zero, built on the unsigned pipe.
`timescale 1ns / 1ps
module bsc_sdiv (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [31:0] num,
  input  logic [31:0] den,
  input  logic [63:0] side_in,
  output logic        out_valid,
  output logic [31:0] quo,
  output logic [63:0] side_out
);
  import bsc_pkg::*;

  logic        neg;
  logic [31:0] an, ad, uq;
  logic [63:0] s_out;
  logic [31:0] neg_q;

  assign neg = num[31] ^ den[31];
  assign an  = num[31] ? 32'(-num) : num;
  assign ad  = den[31] ? 32'(-den) : den;

  bsc_div u_div (
    .clk(clk), .rst(rst), .in_valid(in_valid), .num(an), .den(ad),
    .side_in(side_in), .out_valid(out_valid), .quo(uq), .side_out(s_out)
  );

  always_ff @(posedge clk) begin
    neg_q <= {neg_q[30:0], neg};
  end

  assign quo      = neg_q[31] ? 32'(-uq) : uq;
  assign side_out = s_out;
endmodule

>>> rtl/core/barometric_sensor_compensation.sv
// Top level of the barometric temperature and pressure compensation pipeline.
//  channel | signals                                  | word accepted when
//  input   | start, raw_temp, raw_pressure, busy      | start && !busy
//  config  | cfg_valid, cfg_index, cfg_data, cfg_ready| cfg_valid && cfg_ready
//  result  | done, temp_tenths, pressure_pa, divide_error | done
// One word may enter every cycle; busy stays low.
// The path to done holds two 32-stage divider pipes in series.
// Reset clears all valid bits and loads calibration defaults.
// The receiver cannot stall; results leave on done.
`timescale 1ns / 1ps
module barometric_sensor_compensation (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] raw_temp,
  input  logic [18:0] raw_pressure,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [bsc_pkg::RegIdxW-1:0] cfg_index,
  input  logic [31:0] cfg_data,
  output logic        done,
  output logic signed [15:0] temp_tenths,
  output logic signed [31:0] pressure_pa,
  output logic        divide_error
);
  import bsc_pkg::*;

  cal_t cal;
  logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '{ac1_ac2: '0, ac3_ac4: '0, ac5_ac6: '0, b1_b2: '0, mc_md: '0,
               oss: OssReset};
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_AC1_AC2: cal.ac1_ac2 <= cfg_data;
        REG_AC3_AC4: cal.ac3_ac4 <= cfg_data;
        REG_AC5_AC6: cal.ac5_ac6 <= cfg_data;
        REG_B1_B2:   cal.b1_b2   <= cfg_data;
        REG_MC_MD:   cal.mc_md   <= cfg_data;
        REG_OSS:     cal.oss     <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign ac1 = sx16(cal.ac1_ac2[31:16]);
  assign ac2 = sx16(cal.ac1_ac2[15:0]);
  assign ac3 = sx16(cal.ac3_ac4[31:16]);
  assign ac4 = {16'd0, cal.ac3_ac4[15:0]};
  assign ac5 = {16'd0, cal.ac5_ac6[31:16]};
  assign ac6 = {16'd0, cal.ac5_ac6[15:0]};
  assign b1  = sx16(cal.b1_b2[31:16]);
  assign b2  = sx16(cal.b1_b2[15:0]);
  assign mc  = sx16(cal.mc_md[31:16]);
  assign md  = sx16(cal.mc_md[15:0]);

  // stage 1: (ut - ac6) * ac5
  logic        v1;
  logic [31:0] m1;
  logic [18:0] up1;
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= start;
    m1  <= ({16'd0, raw_temp} - ac6) * ac5;
    up1 <= raw_pressure;
  end

  // stage 2: x1, divisor
  logic        v2;
  logic [31:0] x1t, dv2;
  logic [18:0] up2;
  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    x1t <= asr(m1, 5'd15);
    dv2 <= asr(m1, 5'd15) + md;
    up2 <= up1;
  end

  logic        dz2;
  logic [31:0] dsafe;
  assign dz2   = (dv2 == '0);
  assign dsafe = dz2 ? 32'd1 : dv2;

  logic        v3;
  logic [31:0] x2t;
  logic [63:0] sd3;
  bsc_sdiv u_tdiv (
    .clk(clk), .rst(rst), .in_valid(v2), .num(mc << 11), .den(dsafe),
    .side_in({x1t, dz2, up2, 12'd0}), .out_valid(v3), .quo(x2t), .side_out(sd3)
  );

  // stage 4: b5, b6
  logic        v4, e4;
  logic [31:0] b5_4, b6_4;
  logic [18:0] up4;
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    b5_4 <= sd3[63:32] + x2t;
    b6_4 <= sd3[63:32] + x2t - C4000;
    e4   <= sd3[31];
    up4  <= sd3[30:12];
  end

  // stage 5: products with b6
  logic        v5, e5;
  logic [31:0] b5_5, b6_5, sq5, p_ac2, p_ac3;
  logic [18:0] up5;
  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else     v5 <= v4;
    sq5   <= asr(b6_4 * b6_4, 5'd12);
    p_ac2 <= asr(ac2 * b6_4, 5'd11);
    p_ac3 <= asr(ac3 * b6_4, 5'd13);
    b5_5 <= b5_4; b6_5 <= b6_4; e5 <= e4; up5 <= up4;
  end

  // stage 6: b2 and b1 terms
  logic        v6, e6;
  logic [31:0] b5_6, t_b2, t_b1, q_ac2, q_ac3;
  logic [18:0] up6;
  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else     v6 <= v5;
    t_b2 <= asr(b2 * sq5, 5'd11);
    t_b1 <= asr(b1 * sq5, 5'd16);
    q_ac2 <= p_ac2; q_ac3 <= p_ac3;
    b5_6 <= b5_5; e6 <= e5; up6 <= up5;
  end

  // stage 7: b3 and x3
  logic        v7, e7;
  logic [31:0] b5_7, b3_7, x3_7;
  logic [18:0] up7;
  always_ff @(posedge clk) begin
    if (rst) v7 <= 1'b0;
    else     v7 <= v6;
    b3_7 <= asr((((ac1 << 2) + t_b2 + q_ac2) << cal.oss) + 32'd2, 5'd2);
    x3_7 <= asr(q_ac3 + t_b1 + 32'd2, 5'd2);
    b5_7 <= b5_6; e7 <= e6; up7 <= up6;
  end

  // stage 8: b4 and b7
  logic        v8, e8;
  logic [31:0] b5_8, b4_8, b7_8;
  always_ff @(posedge clk) begin
    if (rst) v8 <= 1'b0;
    else     v8 <= v7;
    b4_8 <= (ac4 * (x3_7 + C32768)) >> 15;
    b7_8 <= ({13'd0, up7} - b3_7) * (C50000 >> cal.oss);
    b5_8 <= b5_7; e8 <= e7;
  end

  logic        e8b, big8;
  logic [31:0] pn, pd;
  assign e8b  = e8 || (b4_8 == '0);
  assign big8 = b7_8[31];
  assign pn   = big8 ? b7_8 : (b7_8 << 1);
  assign pd   = (b4_8 == '0) ? 32'd1 : b4_8;

  logic        v9;
  logic [31:0] pq;
  logic [63:0] sd9;
  bsc_div u_pdiv (
    .clk(clk), .rst(rst), .in_valid(v8), .num(pn), .den(pd),
    .side_in({b5_8, e8b, big8, 30'd0}), .out_valid(v9), .quo(pq), .side_out(sd9)
  );

  // stage 10: p, its square term and the temperature
  logic        v10, e10;
  logic [31:0] p10, sq10, t10;
  always_ff @(posedge clk) begin
    if (rst) v10 <= 1'b0;
    else     v10 <= v9;
    p10  <= sd9[30] ? (pq << 1) : pq;
    sq10 <= asr(sd9[30] ? (pq << 1) : pq, 5'd8) * asr(sd9[30] ? (pq << 1) : pq, 5'd8);
    t10  <= asr(sd9[63:32] + 32'd8, 5'd4);
    e10  <= sd9[31];
  end

  // stage 11: scaled square and linear terms
  logic        v11, e11;
  logic [31:0] p11, a11, c11, t11;
  always_ff @(posedge clk) begin
    if (rst) v11 <= 1'b0;
    else     v11 <= v10;
    a11 <= asr(sq10 * C3038, 5'd16);
    c11 <= asr(CNeg7357 * p10, 5'd16);
    p11 <= p10; t11 <= t10; e11 <= e10;
  end

  // stage 12: output register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= v11;
    divide_error <= e11;
    temp_tenths  <= e11 ? 16'sd0 : $signed(t11[15:0]);
    pressure_pa  <= e11 ? 32'sd0 : $signed(p11 + asr(a11 + c11 + C3791, 5'd4));
  end

  property p_idle_empty;
    @(posedge clk) disable iff (rst) !v1 && !v2 |-> ##1 1'b1;
  endproperty
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    done && divide_error |-> temp_tenths == 0 && pressure_pa == 0)
    else $error("error result not zeroed");
  a_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");
  a_done_src: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(v11)) else $error("done without item");
  a_first: assert property (@(posedge clk) disable iff (rst)
    v1 |-> $past(start)) else $error("stage 1 without start");
  a_chain: assert property (p_idle_empty) else $error("chain");
endmodule
